// ===== design/edf_pkg.sv =====
package edf_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int ORDER_W        = 16;
    localparam int CMD_W          = 3;
    localparam int SLOT_IN_W      = 4;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;
    localparam int OUT_SLOT_W     = 4;
    localparam int OUT_TIME_W     = 32;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 72;

    typedef enum logic [CMD_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_TERMINATE = 3'd1,
        OP_DELAY     = 3'd2,
        OP_SET_DL    = 3'd3,
        OP_BLOCK     = 3'd4,
        OP_RELEASE   = 3'd5,
        OP_TICK      = 3'd6,
        OP_LOAD      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        WHERE_READY = 2'd0,
        WHERE_TIMER = 2'd1,
        WHERE_WAIT  = 2'd2
    } where_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FAIL     = 2'd1,
        STAT_DEADLINE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE_SCAN,
        ST_RELEASE,
        ST_TICK_TIMER,
        ST_TICK_WAIT,
        ST_FIND,
        ST_RESULT
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [SLOT_IN_W-1:0] slot;
        logic [VALUE_W-1:0]   value;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [OUT_SLOT_W-1:0] running_slot;
        logic [OUT_TIME_W-1:0] running_deadline;
        logic [OUT_TIME_W-1:0] tick_now;
        logic [OUT_SLOT_W-1:0] created_slot;
    } res_t;

endpackage

// ===== design/edf_front.sv =====
module edf_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2:0]               s_tuser,
    input  logic [39:0]              s_tdata,
    output logic                     q_valid,
    input  logic                     q_ready,
    output edf_pkg::cmd_t            q_item
);
    import edf_pkg::*;

    cmd_t       buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       in_item;

    // decode the transfer into a command
    always_comb begin
        in_item.op    = op_t'(s_tuser);
        in_item.slot  = s_tdata[SLOT_IN_W-1:0];
        in_item.value = s_tdata[SLOT_IN_W+VALUE_W-1:SLOT_IN_W];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/edf_core.sv =====
module edf_core #(
    parameter int TASK_SLOTS = edf_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = edf_pkg::TIME_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  edf_pkg::cmd_t q_item,
    output logic          res_valid,
    input  logic          res_ready,
    output edf_pkg::res_t res
);
    import edf_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(TASK_SLOTS - 1);

    logic                 used_reg  [TASK_SLOTS];
    where_t               where_reg [TASK_SLOTS];
    logic [TIME_BITS-1:0] dl_reg    [TASK_SLOTS];
    logic [TIME_BITS-1:0] wake_reg  [TASK_SLOTS];
    logic [ORDER_W-1:0]   ord_reg   [TASK_SLOTS];

    state_t               state_reg, state_next;
    cmd_t                 item_reg, item_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [ORDER_W-1:0]   ord_cnt_reg, ord_cnt_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    status_t              status_reg, status_next;
    logic [SLOT_W-1:0]    created_reg, created_next;
    logic                 run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0]    run_idx_reg, run_idx_next;
    logic [TIME_BITS-1:0] run_dl_reg, run_dl_next;
    logic                 srch_valid_reg, srch_valid_next;
    logic [SLOT_W-1:0]    srch_idx_reg, srch_idx_next;
    logic [TIME_BITS-1:0] srch_dl_reg, srch_dl_next;
    logic [ORDER_W-1:0]   srch_age_reg, srch_age_next;

    logic                 w_used_en, w_used, w_where_en, w_dl_en, w_wake_en, w_stamp;
    where_t               w_where;
    logic [SLOT_W-1:0]    w_idx;
    logic [TIME_BITS-1:0] w_dl, w_wake;

    logic [TIME_BITS-1:0] in_val;
    logic [ORDER_W-1:0]   cur_age;
    logic                 cand, better;

    assign in_val  = TIME_BITS'(item_reg.value);
    assign cur_age = ord_cnt_reg - ord_reg[idx_reg];
    assign cand    = used_reg[idx_reg] && (where_reg[idx_reg] == WHERE_READY);
    assign better  = cand && (!srch_valid_reg || (dl_reg[idx_reg] < srch_dl_reg) ||
                     ((dl_reg[idx_reg] == srch_dl_reg) && (cur_age > srch_age_reg)));

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        ord_cnt_next    = ord_cnt_reg;
        tick_next       = tick_reg;
        status_next     = status_reg;
        created_next    = created_reg;
        run_valid_next  = run_valid_reg;
        run_idx_next    = run_idx_reg;
        run_dl_next     = run_dl_reg;
        srch_valid_next = 1'b0;
        srch_idx_next   = srch_idx_reg;
        srch_dl_next    = srch_dl_reg;
        srch_age_next   = srch_age_reg;
        q_ready         = 1'b0;
        res_valid       = 1'b0;
        w_used_en       = 1'b0;
        w_used          = 1'b0;
        w_where_en      = 1'b0;
        w_where         = WHERE_READY;
        w_dl_en         = 1'b0;
        w_dl            = in_val;
        w_wake_en       = 1'b0;
        w_wake          = tick_reg + in_val;
        w_stamp         = 1'b0;
        w_idx           = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_ready      = 1'b1;
                    item_next    = q_item;
                    status_next  = STAT_OK;
                    created_next = '0;
                    idx_next     = '0;
                    w_idx        = run_idx_reg;
                    state_next   = ST_FIND;
                    case (q_item.op)
                        OP_CREATE: begin
                            state_next = ST_CREATE_SCAN;
                        end
                        OP_TERMINATE: begin
                            if (run_valid_reg) begin
                                w_used_en = 1'b1;
                            end else begin
                                status_next = STAT_FAIL;
                            end
                        end
                        OP_DELAY: begin
                            if (run_valid_reg) begin
                                w_wake     = tick_reg + TIME_BITS'(q_item.value);
                                w_wake_en  = 1'b1;
                                w_where_en = 1'b1;
                                w_where    = WHERE_TIMER;
                            end else begin
                                status_next = STAT_FAIL;
                            end
                        end
                        OP_SET_DL: begin
                            if (run_valid_reg) begin
                                w_dl       = TIME_BITS'(q_item.value);
                                w_dl_en    = 1'b1;
                                w_stamp    = 1'b1;
                            end else begin
                                status_next = STAT_FAIL;
                            end
                        end
                        OP_BLOCK: begin
                            if (run_valid_reg) begin
                                w_where_en = 1'b1;
                                w_where    = WHERE_WAIT;
                            end else begin
                                status_next = STAT_FAIL;
                            end
                        end
                        OP_RELEASE: begin
                            if (32'(q_item.slot) < 32'(TASK_SLOTS)) begin
                                idx_next   = SLOT_W'(q_item.slot);
                                state_next = ST_RELEASE;
                            end else begin
                                status_next = STAT_FAIL;
                            end
                        end
                        OP_TICK: begin
                            tick_next  = tick_reg + TIME_BITS'(1);
                            state_next = ST_TICK_TIMER;
                        end
                        OP_LOAD: begin
                            tick_next = TIME_BITS'(q_item.value);
                        end
                        default: begin
                            status_next = STAT_FAIL;
                        end
                    endcase
                end
            end
            ST_CREATE_SCAN: begin
                if (!used_reg[idx_reg]) begin
                    w_used_en    = 1'b1;
                    w_used       = 1'b1;
                    w_dl_en      = 1'b1;
                    w_stamp      = 1'b1;
                    created_next = idx_reg;
                    idx_next     = '0;
                    state_next   = ST_FIND;
                end else if (idx_reg == LAST) begin
                    status_next = STAT_FAIL;
                    idx_next    = '0;
                    state_next  = ST_FIND;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_RELEASE: begin
                if (used_reg[idx_reg] && (where_reg[idx_reg] != WHERE_READY)) begin
                    w_stamp = 1'b1;
                end else begin
                    status_next = STAT_FAIL;
                end
                idx_next   = '0;
                state_next = ST_FIND;
            end
            ST_TICK_TIMER: begin
                if (used_reg[idx_reg] && (where_reg[idx_reg] == WHERE_TIMER) &&
                    ((tick_reg >= wake_reg[idx_reg]) || (tick_reg >= dl_reg[idx_reg]))) begin
                    w_stamp = 1'b1;
                end
                if (idx_reg == LAST) begin
                    idx_next   = '0;
                    state_next = ST_TICK_WAIT;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_TICK_WAIT: begin
                if (used_reg[idx_reg] && (where_reg[idx_reg] == WHERE_WAIT) &&
                    (dl_reg[idx_reg] == tick_reg)) begin
                    w_stamp = 1'b1;
                end
                if (idx_reg == LAST) begin
                    idx_next   = '0;
                    state_next = ST_FIND;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_FIND: begin
                srch_valid_next = srch_valid_reg || better;
                if (better) begin
                    srch_idx_next = idx_reg;
                    srch_dl_next  = dl_reg[idx_reg];
                    srch_age_next = cur_age;
                end
                if (idx_reg == LAST) begin
                    run_valid_next = srch_valid_next;
                    run_idx_next   = srch_idx_next;
                    run_dl_next    = srch_dl_next;
                    if (((item_reg.op == OP_DELAY) || (item_reg.op == OP_BLOCK)) &&
                        (status_reg == STAT_OK) && srch_valid_next &&
                        (tick_reg >= srch_dl_next)) begin
                        status_next = STAT_DEADLINE;
                    end
                    idx_next   = '0;
                    state_next = ST_RESULT;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_RESULT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (w_stamp) begin
            ord_cnt_next = ord_cnt_reg + ORDER_W'(1);
        end
    end

    always_comb begin
        res.status           = status_reg;
        res.running_slot     = run_valid_reg ? OUT_SLOT_W'(run_idx_reg) : '0;
        res.running_deadline = run_valid_reg ? OUT_TIME_W'(run_dl_reg) : '0;
        res.tick_now         = OUT_TIME_W'(tick_reg);
        res.created_slot     = OUT_SLOT_W'(created_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            ord_cnt_reg    <= ORDER_W'(1);
            tick_reg       <= '0;
            run_valid_reg  <= 1'b1;
            run_idx_reg    <= '0;
            run_dl_reg     <= '1;
            srch_valid_reg <= 1'b0;
            status_reg     <= STAT_OK;
            created_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            ord_cnt_reg    <= ord_cnt_next;
            tick_reg       <= tick_next;
            run_valid_reg  <= run_valid_next;
            run_idx_reg    <= run_idx_next;
            run_dl_reg     <= run_dl_next;
            srch_valid_reg <= srch_valid_next;
            status_reg     <= status_next;
            created_reg    <= created_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        srch_idx_reg <= srch_idx_next;
        srch_dl_reg  <= srch_dl_next;
        srch_age_reg <= srch_age_next;
        if (w_wake_en) begin
            wake_reg[w_idx] <= w_wake;
        end
    end

    // slot table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                used_reg[i]  <= (i == 0);
                where_reg[i] <= WHERE_READY;
                dl_reg[i]    <= (i == 0) ? '1 : '0;
                ord_reg[i]   <= '0;
            end
        end else begin
            if (w_used_en) begin
                used_reg[w_idx] <= w_used;
            end
            if (w_dl_en) begin
                dl_reg[w_idx] <= w_dl;
            end
            if (w_stamp) begin
                where_reg[w_idx] <= WHERE_READY;
                ord_reg[w_idx]   <= ord_cnt_reg;
            end else if (w_where_en) begin
                where_reg[w_idx] <= w_where;
            end
        end
    end

    a_cnt_stable_in_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |=> $stable(ord_cnt_reg))
        else $error("stamp counter moved while result pending");

    a_fail_no_created: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status == STAT_FAIL)) |-> (created_reg == '0))
        else $error("failed command reports a created slot");

    a_running_is_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && run_valid_reg) |->
            (used_reg[run_idx_reg] && (where_reg[run_idx_reg] == WHERE_READY) &&
             (dl_reg[run_idx_reg] == run_dl_reg)))
        else $error("running slot is not a ready task");

endmodule

// ===== design/edf_task_scheduler.sv =====
// earliest-deadline-first scheduler over TASK_SLOTS task slots. one command
// transfer in gives one result transfer out. a two-entry command queue takes
// transfers while the scheduler core works, so the input side stays open for up
// to two transfers while a result waits. the core walks the slot table one slot
// per cycle: a terminate, delay, set deadline, block or load command does a scan
// for the new running task, release checks the named slot and then does that
// scan, create does a free-slot scan that stops at the first free slot and then
// the running-task scan, and tick does a timer pass, a waiting pass and then the
// running-task scan, all through the single slot-table scan index.
// slot 0 holds the idle task at reset, with an all-ones deadline
module edf_task_scheduler #(
    parameter int TASK_SLOTS = edf_pkg::TASK_SLOTS_DEF,
    parameter int TIME_BITS  = edf_pkg::TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // command
    input  logic [39:0] s_tdata,   // task_slot, value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [71:0] m_tdata    // running_slot, running_deadline, tick_now, created_slot
);
    import edf_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_item;
    res_t res;

    edf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    edf_core #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {res.created_slot, res.tick_now, res.running_deadline, res.running_slot};

endmodule

// ===== dv/edf_task_scheduler_tb.sv =====
module edf_task_scheduler_tb;
    import edf_pkg::*;

    localparam int NSLOT     = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 725;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  run_slot;
        logic [31:0] run_dl;
        logic [31:0] tick_now;
        logic [3:0]  new_slot;
    } sched_res_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [31:0] value;
    } sched_cmd_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;
    logic [71:0] m_tdata;

    edf_task_scheduler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // scheduler shadow state
    logic        sh_used [NSLOT];
    logic [1:0]  sh_where [NSLOT];
    logic [31:0] sh_dl [NSLOT];
    logic [31:0] sh_wake [NSLOT];
    logic [15:0] sh_stamp [NSLOT];
    logic [15:0] sh_next_stamp;
    logic [31:0] sh_tick;
    logic [31:0] sh_tick_guess;

    sched_cmd_t  cmd_q [$];
    sched_res_t  sched_res_q [$];
    int          fail_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          wdog;
    bit          stim_done;

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic void shadow_reset();
        for (int i = 0; i < NSLOT; i++) begin
            sh_used[i]  = 1'b0;
            sh_where[i] = WHERE_READY;
            sh_dl[i]    = '0;
            sh_wake[i]  = '0;
            sh_stamp[i] = '0;
        end
        sh_used[0]    = 1'b1;
        sh_dl[0]      = '1;
        sh_next_stamp = 16'd1;
        sh_tick       = '0;
    endfunction

    function automatic void enter_ready(int s);
        sh_where[s]   = WHERE_READY;
        sh_stamp[s]   = sh_next_stamp;
        sh_next_stamp = sh_next_stamp + 16'd1;
    endfunction

    function automatic int earliest_ready();
        int          best;
        logic [15:0] best_age;
        logic [15:0] age;
        best     = -1;
        best_age = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_used[i] && sh_where[i] == WHERE_READY) begin
                age = sh_next_stamp - sh_stamp[i];
                if (best < 0 || sh_dl[i] < sh_dl[best] ||
                    (sh_dl[i] == sh_dl[best] && age > best_age)) begin
                    best     = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    function automatic sched_res_t schedule_step(sched_cmd_t c);
        sched_res_t r;
        int         run;
        r   = '0;
        run = earliest_ready();
        case (op_t'(c.op))
            OP_CREATE: begin
                r.status = STAT_FAIL;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!sh_used[i] && r.status == STAT_FAIL) begin
                        sh_used[i] = 1'b1;
                        sh_dl[i]   = c.value;
                        sh_wake[i] = '0;
                        enter_ready(i);
                        r.new_slot = i[3:0];
                        r.status   = STAT_OK;
                    end
                end
            end
            OP_TERMINATE: begin
                if (run < 0) r.status = STAT_FAIL;
                else sh_used[run] = 1'b0;
            end
            OP_DELAY: begin
                if (run < 0) begin
                    r.status = STAT_FAIL;
                end else begin
                    sh_wake[run]  = sh_tick + c.value;
                    sh_where[run] = WHERE_TIMER;
                end
            end
            OP_SET_DL: begin
                if (run < 0) begin
                    r.status = STAT_FAIL;
                end else begin
                    sh_dl[run] = c.value;
                    enter_ready(run);
                end
            end
            OP_BLOCK: begin
                if (run < 0) r.status = STAT_FAIL;
                else sh_where[run] = WHERE_WAIT;
            end
            OP_RELEASE: begin
                if (!sh_used[c.slot] || sh_where[c.slot] == WHERE_READY) r.status = STAT_FAIL;
                else enter_ready(c.slot);
            end
            OP_TICK: begin
                sh_tick = sh_tick + 32'd1;
                for (int i = 0; i < NSLOT; i++) begin
                    if (sh_used[i] && sh_where[i] == WHERE_TIMER &&
                        (sh_tick >= sh_wake[i] || sh_tick >= sh_dl[i]))
                        enter_ready(i);
                end
                for (int i = 0; i < NSLOT; i++) begin
                    if (sh_used[i] && sh_where[i] == WHERE_WAIT && sh_dl[i] == sh_tick)
                        enter_ready(i);
                end
            end
            default: sh_tick = c.value;
        endcase
        run = earliest_ready();
        if ((c.op == OP_DELAY || c.op == OP_BLOCK) && r.status == STAT_OK &&
            run >= 0 && sh_tick >= sh_dl[run])
            r.status = STAT_DEADLINE;
        if (run >= 0) begin
            r.run_slot = run[3:0];
            r.run_dl   = sh_dl[run];
        end
        r.tick_now = sh_tick;
        return r;
    endfunction

    function automatic sched_cmd_t make_cmd(logic [2:0] op, logic [3:0] slot,
                                            logic [31:0] value);
        sched_cmd_t c;
        c.op    = op;
        c.slot  = slot;
        c.value = value;
        return c;
    endfunction

    // small deadlines near the tick keep wakeups and deadline hits frequent
    function automatic logic [31:0] near_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'hffff_ffff - $urandom_range(0, 3);
            default: return sh_tick_guess + $urandom_range(0, 12);
        endcase
    endfunction

    function automatic sched_cmd_t random_cmd();
        int          k;
        logic [2:0]  op;
        k = $urandom_range(0, 99);
        if (k < 18) op = OP_CREATE;
        else if (k < 26) op = OP_TERMINATE;
        else if (k < 36) op = OP_DELAY;
        else if (k < 44) op = OP_SET_DL;
        else if (k < 52) op = OP_BLOCK;
        else if (k < 64) op = OP_RELEASE;
        else if (k < 96) op = OP_TICK;
        else op = OP_LOAD;
        if (op == OP_TICK) sh_tick_guess = sh_tick_guess + 32'd1;
        if (op == OP_LOAD) begin
            return make_cmd(op, 4'($urandom), ($urandom_range(0, 3) == 0) ? $urandom
                            : $urandom_range(0, 40));
        end
        return make_cmd(op, 4'($urandom), (op == OP_DELAY) ? (($urandom_range(0, 7) == 0)
                        ? $urandom : $urandom_range(0, 6)) : near_value());
    endfunction

    initial begin
        sched_cmd_t c;
        aresetn       = 1'b0;
        fail_cnt      = 0;
        stim_done     = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 83;
        sh_tick_guess = '0;
        shadow_reset();
        // directed
        cmd_q.push_back(make_cmd(OP_RELEASE, 4'd0, 32'd0));
        cmd_q.push_back(make_cmd(OP_RELEASE, 4'd15, 32'hffff_ffff));
        for (int i = 0; i < 16; i++)
            cmd_q.push_back(make_cmd(OP_CREATE, 4'(i), (i < 2) ? 32'd5 : 32'd100 + i));
        cmd_q.push_back(make_cmd(OP_SET_DL, 4'd0, 32'd5));
        cmd_q.push_back(make_cmd(OP_DELAY, 4'd0, 32'hffff_ffff));
        cmd_q.push_back(make_cmd(OP_BLOCK, 4'd0, 32'd0));
        cmd_q.push_back(make_cmd(OP_RELEASE, 4'd2, 32'd0));
        cmd_q.push_back(make_cmd(OP_LOAD, 4'd0, 32'hffff_fffe));
        cmd_q.push_back(make_cmd(OP_TICK, 4'd0, 32'd0));
        cmd_q.push_back(make_cmd(OP_TICK, 4'd0, 32'd0));
        cmd_q.push_back(make_cmd(OP_LOAD, 4'd0, 32'd0));
        for (int i = 0; i < 17; i++)
            cmd_q.push_back(make_cmd(OP_TERMINATE, 4'd0, 32'd0));
        cmd_q.push_back(make_cmd(OP_DELAY, 4'd0, 32'd1));
        cmd_q.push_back(make_cmd(OP_SET_DL, 4'd0, 32'd1));
        cmd_q.push_back(make_cmd(OP_BLOCK, 4'd0, 32'd1));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                wait (cmd_q.size() == 0);
                send_idle_pct = 83;
                recv_idle_pct = 16;
            end
            if (i == 2 * N_RANDOM / 3) begin
                wait (cmd_q.size() == 0);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c = random_cmd();
            cmd_q.push_back(c);
            if (cmd_q.size() > 8) wait (cmd_q.size() <= 4);
        end
        wait (cmd_q.size() == 0 && !s_tvalid);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tuser  <= '0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) sched_res_q.push_back(schedule_step({s_tuser, s_tdata[3:0],
                                                               s_tdata[35:4]}));
            if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= cmd_q[0].op;
                s_tdata  <= {4'd0, cmd_q[0].value, cmd_q[0].slot};
                void'(cmd_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sched_res_t got;
        sched_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            wdog     <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[67:36],
                       m_tdata[71:68]};
                if (sched_res_q.size() == 0) begin
                    $display("%0t unexpected result transfer: actual %h", $time, got);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    want = sched_res_q.pop_front();
                    if (got !== want) begin
                        $display("%0t result mismatch: expected %h actual %h",
                                 $time, want, got);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) wdog <= 0;
            else wdog <= wdog + 1;
        end
    end

    initial begin
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        wait (stim_done);
        while (sched_res_q.size() != 0 && wdog < WDOG_MAX) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (wdog >= WDOG_MAX || sched_res_q.size() != 0) fail_cnt = fail_cnt + 1;
        if (fail_cnt == 0) $display("edf_task_scheduler verification clean");
        else $display("edf_task_scheduler verification failed");
        $finish;
    end

    initial begin
        wait (wdog >= WDOG_MAX);
        $display("edf_task_scheduler verification failed");
        $finish;
    end

endmodule
